[hdl/ttbr_pkg.sv]
// Shared types and constants for the two-tier buffer recycler.
// No dependencies; every other file imports this package.
package ttbr_pkg;

	localparam int PORT_HANDLE_W = 16;
	localparam int CAP_W         = 11;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 11;
	localparam int COUNT_W       = 32;

	// ring capacity used when the capacity register holds zero
	localparam logic [CAP_W-1:0] DEFAULT_RING = CAP_W'(512);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RING_CAP = 2'd0,
		REG_DMA_MAP  = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		OUT_FROM_CACHE = 3'd0,
		OUT_FROM_RING  = 3'd1,
		OUT_FRESH      = 3'd2,
		OUT_CACHED     = 3'd3,
		OUT_RINGED     = 3'd4,
		OUT_RELEASED   = 3'd5
	} outcome_t;

	typedef enum logic [1:0] {
		DMA_NONE  = 2'd0,
		DMA_MAP   = 2'd1,
		DMA_UNMAP = 2'd2
	} dma_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DONE = 2'b10
	} state_t;

	// push/pop strobes from the controller to one tier
	typedef struct packed {
		logic push;
		logic pop;
	} tier_op_t;

	// occupancy status from one tier to the controller
	typedef struct packed {
		logic empty;
		logic full;
	} tier_stat_t;

endpackage

[hdl/ttbr_ifs.sv]
// Channel interfaces of the buffer recycler: request, result, config write.
// Depends on ttbr_pkg.
interface ttbr_req_if import ttbr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [PORT_HANDLE_W-1:0] page_handle;
	logic                     shared_reference;
	logic                     direct_allowed;

	modport source(output valid, command, page_handle, shared_reference, direct_allowed,
		input ready);
	modport sink(input valid, command, page_handle, shared_reference, direct_allowed,
		output ready);
endinterface

interface ttbr_rsp_if import ttbr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [PORT_HANDLE_W-1:0] result_handle;
	logic [2:0]               outcome;
	logic [1:0]               dma_action;
	logic [COUNT_W-1:0]       hold_total;
	logic [COUNT_W-1:0]       release_total;

	modport source(output valid, result_handle, outcome, dma_action, hold_total,
		release_total, input ready);
	modport sink(input valid, result_handle, outcome, dma_action, hold_total,
		release_total, output ready);
endinterface

interface ttbr_cfg_if import ttbr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hdl/ttbr_cache.sv]
// LIFO direct cache: stack memory with a fill counter and registered read.
// Depends on ttbr_pkg.
module ttbr_cache import ttbr_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int W     = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  tier_op_t     op,
	input  logic [W-1:0] wdata,
	output tier_stat_t   stat,
	output logic [W-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [FW-1:0] fill_q;
	logic [FW-1:0] top;
	logic [W-1:0]  rdata_q;

	assign top        = fill_q - FW'(1);
	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == FW'(DEPTH));
	assign rdata      = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (op.push) begin
			fill_q <= fill_q + FW'(1);
		end else if (op.pop) begin
			fill_q <= top;
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[fill_q[AW-1:0]] <= wdata;
		end
		if (op.pop) begin
			rdata_q <= mem[top[AW-1:0]];
		end
	end

endmodule

[hdl/ttbr_ring.sv]
// FIFO ring: circular memory with head, tail and fill, capacity-limited.
// Depends on ttbr_pkg.
module ttbr_ring import ttbr_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int W     = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tier_op_t         op,
	input  logic [W-1:0]     wdata,
	input  logic [CAP_W-1:0] capacity,
	output tier_stat_t       stat,
	output logic [W-1:0]     rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int LW = (FW > CAP_W) ? FW : CAP_W;

	logic [W-1:0]     mem [DEPTH];
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic [FW-1:0]    fill_q;
	logic [W-1:0]     rdata_q;
	logic [CAP_W-1:0] cap;
	logic [LW-1:0]    cap_x;
	logic [LW-1:0]    limit;

	// head and tail wrap at the physical depth, not the capacity
	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
		next_idx = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
	endfunction

	assign cap        = (capacity == '0) ? DEFAULT_RING : capacity;
	assign cap_x      = LW'(cap);
	assign limit      = (cap_x > LW'(DEPTH)) ? LW'(DEPTH) : cap_x;
	assign stat.empty = (fill_q == '0);
	assign stat.full  = (LW'(fill_q) >= limit);
	assign rdata      = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (op.push) begin
				tail_q <= next_idx(tail_q);
				fill_q <= fill_q + FW'(1);
			end else if (op.pop) begin
				head_q <= next_idx(head_q);
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[tail_q] <= wdata;
		end
		if (op.pop) begin
			rdata_q <= mem[head_q];
		end
	end

endmodule

[hdl/two_tier_buffer_recycler.sv]
// Two-tier buffer recycler: request decode and sequencing, counters, result register.
// Depends on ttbr_pkg, ttbr_ifs, ttbr_cache and ttbr_ring.
//
// Usage:
//   req  - one request per handshake: command 0 allocates a buffer, 1 returns
//          page_handle (with shared_reference / direct_allowed qualifiers).
//   rsp  - exactly one result per request, in order: handle served or acted
//          on, outcome, DMA action and the running hold/release totals.
//   cfg  - register writes (ring capacity, DMA map enable); always ready,
//          write only while no request is in flight.
// Timing: a request is accepted in S_IDLE, the tier memory is read or written on that
//   edge, and in S_DONE the result goes into the output register once it is free.
//   No new request is taken until that result has been loaded (req.ready is high only
//   in S_IDLE); the cache and ring memories have a registered read.
// Stall: the output register holds a finished result while rsp.ready is low;
//   the next request is still taken, and its result waits until the register
//   frees up.
// Reset: fills, pointers, counters, config registers, state and rsp valid clear at
//   once; memories and data registers are not cleared (fill counters mark valid entries).
module two_tier_buffer_recycler import ttbr_pkg::*; #(
	parameter int CACHE_DEPTH = 128,
	parameter int RING_DEPTH  = 1024,
	parameter int HANDLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	ttbr_req_if.sink   req,
	ttbr_rsp_if.source rsp,
	ttbr_cfg_if.sink   cfg
);

	localparam int XW = (HANDLE_BITS > PORT_HANDLE_W) ? HANDLE_BITS : PORT_HANDLE_W;

	state_t                 state_q;
	logic [CAP_W-1:0]       ring_cap_q;
	logic                   dma_en_q;
	logic [COUNT_W-1:0]     hold_q;
	logic [COUNT_W-1:0]     release_q;

	outcome_t               outcome_s1;
	dma_t                   dma_s1;
	logic [HANDLE_BITS-1:0] handle_s1;

	logic                   rsp_valid_q;
	logic [PORT_HANDLE_W-1:0] rsp_handle_q;
	outcome_t               rsp_outcome_q;
	dma_t                   rsp_dma_q;
	logic [COUNT_W-1:0]     rsp_hold_q;
	logic [COUNT_W-1:0]     rsp_release_q;

	logic                   accept;
	logic                   out_free;
	logic [XW-1:0]          handle_in_x;
	logic [HANDLE_BITS-1:0] handle_in;
	logic [HANDLE_BITS-1:0] handle_sel;
	logic [XW-1:0]          handle_out_x;

	tier_op_t               cache_op;
	tier_op_t               ring_op;
	tier_stat_t             cache_stat;
	tier_stat_t             ring_stat;
	logic [HANDLE_BITS-1:0] cache_rdata;
	logic [HANDLE_BITS-1:0] ring_rdata;

	outcome_t               outcome_d;
	dma_t                   dma_d;

	assign accept      = req.valid && req.ready;
	assign req.ready   = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign out_free    = !rsp_valid_q || rsp.ready;
	assign handle_in_x = XW'(req.page_handle);
	assign handle_in   = handle_in_x[HANDLE_BITS-1:0];

	// request decode: pick tier, outcome and DMA action from the command, qualifiers and current fill status
	always_comb begin
		cache_op  = '0;
		ring_op   = '0;
		outcome_d = OUT_RELEASED;
		dma_d     = DMA_NONE;
		if (!req.command) begin
			if (!cache_stat.empty) begin
				cache_op.pop = accept;
				outcome_d    = OUT_FROM_CACHE;
			end else if (!ring_stat.empty) begin
				ring_op.pop = accept;
				outcome_d   = OUT_FROM_RING;
			end else begin
				outcome_d = OUT_FRESH;
				dma_d     = dma_en_q ? DMA_MAP : DMA_NONE;
			end
		end else begin
			if (req.shared_reference) begin
				outcome_d = OUT_RELEASED;
			end else if (req.direct_allowed && !cache_stat.full) begin
				cache_op.push = accept;
				outcome_d     = OUT_CACHED;
			end else if (!ring_stat.full) begin
				ring_op.push = accept;
				outcome_d    = OUT_RINGED;
			end else begin
				outcome_d = OUT_RELEASED;
			end
			if (outcome_d == OUT_RELEASED) begin
				dma_d = dma_en_q ? DMA_UNMAP : DMA_NONE;
			end
		end
	end

	ttbr_cache #(
		.DEPTH (CACHE_DEPTH),
		.W     (HANDLE_BITS)
	) u_cache (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (cache_op),
		.wdata  (handle_in),
		.stat   (cache_stat),
		.rdata  (cache_rdata)
	);

	ttbr_ring #(
		.DEPTH (RING_DEPTH),
		.W     (HANDLE_BITS)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (ring_op),
		.wdata    (handle_in),
		.capacity (ring_cap_q),
		.stat     (ring_stat),
		.rdata    (ring_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_cap_q <= '0;
			dma_en_q   <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_RING_CAP: ring_cap_q <= cfg.data[CAP_W-1:0];
				REG_DMA_MAP:  dma_en_q   <= cfg.data[0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= '0;
			release_q <= '0;
		end else if (accept) begin
			if (outcome_d == OUT_FRESH) begin
				hold_q <= hold_q + COUNT_W'(1);
			end
			if (outcome_d == OUT_RELEASED) begin
				release_q <= release_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			outcome_s1 <= outcome_d;
			dma_s1     <= dma_d;
			handle_s1  <= handle_in;
		end
	end

	always_comb begin
		case (outcome_s1)
			OUT_FROM_CACHE: handle_sel = cache_rdata;
			OUT_FROM_RING:  handle_sel = ring_rdata;
			OUT_FRESH:      handle_sel = '0;
			default:        handle_sel = handle_s1;
		endcase
	end

	assign handle_out_x = XW'(handle_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (rsp.ready) begin
						rsp_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload, loaded as the request finishes
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_handle_q  <= handle_out_x[PORT_HANDLE_W-1:0];
			rsp_outcome_q <= outcome_s1;
			rsp_dma_q     <= dma_s1;
			rsp_hold_q    <= hold_q;
			rsp_release_q <= release_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.result_handle = rsp_handle_q;
	assign rsp.outcome       = rsp_outcome_q;
	assign rsp.dma_action    = rsp_dma_q;
	assign rsp.hold_total    = rsp_hold_q;
	assign rsp.release_total = rsp_release_q;

endmodule
